@@ sv/smbus_master_transfer_sequencer_macros.svh @@
// ----------------------------------------------------------------------------
// smbus master transfer sequencer assertion macros
// concurrent checks, empty when synthesised
// ----------------------------------------------------------------------------
`ifndef SMBUS_MASTER_TRANSFER_SEQUENCER_MACROS_SVH
`define SMBUS_MASTER_TRANSFER_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define SMBMTS_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("smbmts assertion failed");
`define SMBMTS_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smbmts assertion failed");
`else
`define SMBMTS_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define SMBMTS_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif

`endif

@@ sv/smbmts_pkg.sv @@
// ----------------------------------------------------------------------------
// smbmts_pkg
// shared codes, constants and result type of the smbus transfer sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package smbmts_pkg;

  localparam int READ_DEPTH_DEF  = 32;
  localparam int WRITE_BYTES_DEF = 2;

  localparam logic [7:0] ADDR_MASK = 8'hFE;

  typedef enum logic [2:0] {
    REQ_WRITE      = 3'd0,
    REQ_READ       = 3'd1,
    REQ_START_SENT = 3'd2,
    REQ_BYTE_SENT  = 3'd3,
    REQ_BYTE_RCVD  = 3'd4,
    REQ_OTHER      = 3'd5,
    REQ_TIMEOUT    = 3'd6
  } req_type_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        start_cmd;
    logic        stop_cmd;
    logic        ack_out;
    logic        rx_store_valid;
    logic [4:0]  rx_index;
    logic [7:0]  rx_data;
    logic        bus_reset;
    logic        busy_res;
    logic        timed_out;
    logic [31:0] error_count;
  } res_t;

endpackage

`default_nettype wire

@@ sv/smbmts_step.sv @@
// ----------------------------------------------------------------------------
// smbmts_step
// next state and result of one transaction, purely combinational
// ----------------------------------------------------------------------------
`default_nettype none

module smbmts_step #(
  parameter int READ_DEPTH  = smbmts_pkg::READ_DEPTH_DEF,
  parameter int WRITE_BYTES = smbmts_pkg::WRITE_BYTES_DEF,
  parameter int CNT_W       = $clog2(READ_DEPTH + 1)
) (
  input  wire logic [2:0]       req_type,
  input  wire logic [7:0]       target_address,
  input  wire logic [7:0]       write_byte_first,
  input  wire logic [7:0]       write_byte_second,
  input  wire logic [7:0]       read_length,
  input  wire logic             ack_in,
  input  wire logic             arb_lost,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             busy,
  input  wire logic             rd_mode,
  input  wire logic             tmo,
  input  wire logic [31:0]      err,
  input  wire logic [1:0]       sent_cnt,
  input  wire logic [CNT_W-1:0] rx_cnt,
  input  wire logic [7:0]       tgt,
  input  wire logic [7:0]       pend0,
  input  wire logic [7:0]       pend1,
  input  wire logic [CNT_W-1:0] req_cnt,
  output logic                  busy_nxt,
  output logic                  rd_mode_nxt,
  output logic                  tmo_nxt,
  output logic [31:0]           err_nxt,
  output logic [1:0]            sent_cnt_nxt,
  output logic [CNT_W-1:0]      rx_cnt_nxt,
  output logic [7:0]            tgt_nxt,
  output logic [7:0]            pend0_nxt,
  output logic [7:0]            pend1_nxt,
  output logic [CNT_W-1:0]      req_cnt_nxt,
  output smbmts_pkg::res_t      res
);

  localparam logic [8:0]       DEPTH_9  = 9'(READ_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(READ_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C    = CNT_W'(1);
  localparam logic [1:0]       WBYTES_2 = 2'(WRITE_BYTES);

  logic [CNT_W-1:0] len_sat;
  logic [6:0]       idx_w;
  logic [1:0]       sent_m1;

  always_comb begin
    if (read_length == 8'd0) begin
      len_sat = ONE_C;
    end else if ({1'b0, read_length} > DEPTH_9) begin
      len_sat = DEPTH_C;
    end else begin
      len_sat = CNT_W'(read_length);
    end
  end

  assign idx_w   = 7'(rx_cnt) - 7'd1;
  assign sent_m1 = sent_cnt - 2'd1;

  always_comb begin
    busy_nxt     = busy;
    rd_mode_nxt  = rd_mode;
    tmo_nxt      = tmo;
    err_nxt      = err;
    sent_cnt_nxt = sent_cnt;
    rx_cnt_nxt   = rx_cnt;
    tgt_nxt      = tgt;
    pend0_nxt    = pend0;
    pend1_nxt    = pend1;
    req_cnt_nxt  = req_cnt;
    res          = '0;

    unique case (req_type)
      smbmts_pkg::REQ_WRITE, smbmts_pkg::REQ_READ: begin
        if (!busy) begin
          busy_nxt      = 1'b1;
          tmo_nxt       = 1'b0;
          tgt_nxt       = target_address;
          res.start_cmd = 1'b1;
          if (req_type == smbmts_pkg::REQ_WRITE) begin
            rd_mode_nxt = 1'b0;
            pend0_nxt   = write_byte_first;
            pend1_nxt   = write_byte_second;
          end else begin
            rd_mode_nxt = 1'b1;
            req_cnt_nxt = len_sat;
          end
        end
      end
      smbmts_pkg::REQ_TIMEOUT: begin
        res.bus_reset = 1'b1;
        busy_nxt      = 1'b0;
        tmo_nxt       = 1'b1;
      end
      smbmts_pkg::REQ_START_SENT, smbmts_pkg::REQ_BYTE_SENT,
      smbmts_pkg::REQ_BYTE_RCVD, smbmts_pkg::REQ_OTHER: begin
        if (arb_lost || req_type == smbmts_pkg::REQ_OTHER) begin
          res.bus_reset = 1'b1;
          busy_nxt      = 1'b0;
          err_nxt       = err + 32'd1;
        end else if (req_type == smbmts_pkg::REQ_START_SENT) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = (tgt & smbmts_pkg::ADDR_MASK) | {7'd0, rd_mode};
          rx_cnt_nxt   = ONE_C;
          sent_cnt_nxt = 2'd1;
        end else if (req_type == smbmts_pkg::REQ_BYTE_SENT) begin
          if (ack_in) begin
            if (!rd_mode) begin
              if (sent_cnt != 2'd0 && sent_cnt <= WBYTES_2) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = sent_m1[0] ? pend1 : pend0;
                sent_cnt_nxt = sent_cnt + 2'd1;
              end else begin
                res.stop_cmd = 1'b1;
                busy_nxt     = 1'b0;
              end
            end
          end else begin
            res.stop_cmd  = 1'b1;
            res.start_cmd = 1'b1;
            err_nxt       = err + 32'd1;
          end
        end else begin
          res.rx_store_valid = 1'b1;
          res.rx_index       = idx_w[4:0];
          res.rx_data        = rx_byte;
          if (rx_cnt < req_cnt) begin
            res.ack_out = 1'b1;
            rx_cnt_nxt  = rx_cnt + ONE_C;
          end else begin
            res.stop_cmd = 1'b1;
            busy_nxt     = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res.busy_res    = busy_nxt;
    res.timed_out   = tmo_nxt;
    res.error_count = err_nxt;
  end

endmodule

`default_nettype wire

@@ sv/smbus_master_transfer_sequencer.sv @@
// ----------------------------------------------------------------------------
// smbus_master_transfer_sequencer
// result: an accepted transaction's result is registered and shows on out_* in the next cycle
// throughput: one transaction per cycle while out_stall is low, set by the single result register
// reset: synchronous rst_n clears busy, timeout and error count and loads one into the counters
// ----------------------------------------------------------------------------
`default_nettype none

`include "smbus_master_transfer_sequencer_macros.svh"

module smbus_master_transfer_sequencer #(
  parameter int READ_DEPTH  = smbmts_pkg::READ_DEPTH_DEF,
  parameter int WRITE_BYTES = smbmts_pkg::WRITE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_target_address,
  input  wire logic [7:0]  in_write_byte_first,
  input  wire logic [7:0]  in_write_byte_second,
  input  wire logic [7:0]  in_read_length,
  input  wire logic        in_ack_in,
  input  wire logic        in_arb_lost,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_start_cmd,
  output logic             out_stop_cmd,
  output logic             out_ack_out,
  output logic             out_rx_store_valid,
  output logic [4:0]       out_rx_index,
  output logic [7:0]       out_rx_data,
  output logic             out_bus_reset,
  output logic             out_busy_res,
  output logic             out_timed_out,
  output logic [31:0]      out_error_count
);

  localparam int CNT_W = $clog2(READ_DEPTH + 1);

  logic             in_acc;
  logic             out_valid_r, out_valid_nxt;
  smbmts_pkg::res_t res_r, res_nxt;

  logic             busy_r, busy_nxt;
  logic             rd_mode_r, rd_mode_nxt;
  logic             tmo_r, tmo_nxt;
  logic [31:0]      err_r, err_nxt;
  logic [1:0]       sent_cnt_r, sent_cnt_nxt;
  logic [CNT_W-1:0] rx_cnt_r, rx_cnt_nxt;
  logic [7:0]       tgt_r, tgt_nxt;
  logic [7:0]       pend0_r, pend0_nxt;
  logic [7:0]       pend1_r, pend1_nxt;
  logic [CNT_W-1:0] req_cnt_r, req_cnt_nxt;

  assign in_stall      = out_valid_r & out_stall;
  assign in_acc        = in_valid & ~in_stall;
  assign out_valid_nxt = in_acc | (out_valid_r & out_stall);

  smbmts_step #(
    .READ_DEPTH  (READ_DEPTH),
    .WRITE_BYTES (WRITE_BYTES),
    .CNT_W       (CNT_W)
  ) u_step (
    .req_type          (in_req_type),
    .target_address    (in_target_address),
    .write_byte_first  (in_write_byte_first),
    .write_byte_second (in_write_byte_second),
    .read_length       (in_read_length),
    .ack_in            (in_ack_in),
    .arb_lost          (in_arb_lost),
    .rx_byte           (in_rx_byte),
    .busy              (busy_r),
    .rd_mode           (rd_mode_r),
    .tmo               (tmo_r),
    .err               (err_r),
    .sent_cnt          (sent_cnt_r),
    .rx_cnt            (rx_cnt_r),
    .tgt               (tgt_r),
    .pend0             (pend0_r),
    .pend1             (pend1_r),
    .req_cnt           (req_cnt_r),
    .busy_nxt          (busy_nxt),
    .rd_mode_nxt       (rd_mode_nxt),
    .tmo_nxt           (tmo_nxt),
    .err_nxt           (err_nxt),
    .sent_cnt_nxt      (sent_cnt_nxt),
    .rx_cnt_nxt        (rx_cnt_nxt),
    .tgt_nxt           (tgt_nxt),
    .pend0_nxt         (pend0_nxt),
    .pend1_nxt         (pend1_nxt),
    .req_cnt_nxt       (req_cnt_nxt),
    .res               (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      rd_mode_r   <= 1'b0;
      tmo_r       <= 1'b0;
      err_r       <= '0;
      sent_cnt_r  <= 2'd1;
      rx_cnt_r    <= CNT_W'(1);
      tgt_r       <= '0;
      pend0_r     <= '0;
      pend1_r     <= '0;
      req_cnt_r   <= CNT_W'(1);
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        busy_r     <= busy_nxt;
        rd_mode_r  <= rd_mode_nxt;
        tmo_r      <= tmo_nxt;
        err_r      <= err_nxt;
        sent_cnt_r <= sent_cnt_nxt;
        rx_cnt_r   <= rx_cnt_nxt;
        tgt_r      <= tgt_nxt;
        pend0_r    <= pend0_nxt;
        pend1_r    <= pend1_nxt;
        req_cnt_r  <= req_cnt_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tx_valid       = res_r.tx_valid;
  assign out_tx_byte        = res_r.tx_byte;
  assign out_start_cmd      = res_r.start_cmd;
  assign out_stop_cmd       = res_r.stop_cmd;
  assign out_ack_out        = res_r.ack_out;
  assign out_rx_store_valid = res_r.rx_store_valid;
  assign out_rx_index       = res_r.rx_index;
  assign out_rx_data        = res_r.rx_data;
  assign out_bus_reset      = res_r.bus_reset;
  assign out_busy_res       = res_r.busy_res;
  assign out_timed_out      = res_r.timed_out;
  assign out_error_count    = res_r.error_count;

  `SMBMTS_ASSERT_NXT(a_tmo_idle, clk, rst_n, in_acc && in_req_type == smbmts_pkg::REQ_TIMEOUT, !busy_r && tmo_r)
  `SMBMTS_ASSERT_NXT(a_err_step, clk, rst_n, in_acc, err_r == $past(err_r) || err_r == $past(err_r) + 32'd1)
  `SMBMTS_ASSERT_NXT(a_err_hold, clk, rst_n, !in_acc, $stable(err_r) && $stable(busy_r))
  `SMBMTS_ASSERT_NXT(a_req_busy, clk, rst_n, in_acc && (in_req_type == smbmts_pkg::REQ_WRITE || in_req_type == smbmts_pkg::REQ_READ), busy_r && out_busy_res)
  `SMBMTS_ASSERT_IMP(a_out_err, clk, rst_n, out_valid_r, out_error_count == err_r)

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: smbus master transfer sequencer testbench
// drives request and bus status transactions through the valid/stall input,
// predicts results by a behavioural sequencer model, or fixed for early rows,
// checks each one field by field, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_UNDEF = 3'd7;
  localparam int         RANDOM_ITEMS = 1400;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] addr;
    logic [7:0] wb0;
    logic [7:0] wb1;
    logic [7:0] rlen;
    logic       ack;
    logic       arb;
    logic [7:0] rxb;
  } bus_txn_t;

  typedef struct packed {
    bus_txn_t         txn;
    logic             typed;
    smbmts_pkg::res_t want;
  } bus_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_req_type;
  logic [7:0]  in_target_address;
  logic [7:0]  in_write_byte_first;
  logic [7:0]  in_write_byte_second;
  logic [7:0]  in_read_length;
  logic        in_ack_in;
  logic        in_arb_lost;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_start_cmd;
  logic        out_stop_cmd;
  logic        out_ack_out;
  logic        out_rx_store_valid;
  logic [4:0]  out_rx_index;
  logic [7:0]  out_rx_data;
  logic        out_bus_reset;
  logic        out_busy_res;
  logic        out_timed_out;
  logic [31:0] out_error_count;

  smbmts_pkg::res_t seen;
  assign seen = {out_tx_valid, out_tx_byte, out_start_cmd, out_stop_cmd, out_ack_out,
                 out_rx_store_valid, out_rx_index, out_rx_data, out_bus_reset,
                 out_busy_res, out_timed_out, out_error_count};

  smbus_master_transfer_sequencer dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_target_address    (in_target_address),
    .in_write_byte_first  (in_write_byte_first),
    .in_write_byte_second (in_write_byte_second),
    .in_read_length       (in_read_length),
    .in_ack_in            (in_ack_in),
    .in_arb_lost          (in_arb_lost),
    .in_rx_byte           (in_rx_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_tx_valid         (out_tx_valid),
    .out_tx_byte          (out_tx_byte),
    .out_start_cmd        (out_start_cmd),
    .out_stop_cmd         (out_stop_cmd),
    .out_ack_out          (out_ack_out),
    .out_rx_store_valid   (out_rx_store_valid),
    .out_rx_index         (out_rx_index),
    .out_rx_data          (out_rx_data),
    .out_bus_reset        (out_bus_reset),
    .out_busy_res         (out_busy_res),
    .out_timed_out        (out_timed_out),
    .out_error_count      (out_error_count)
  );

  // sequencer model state
  logic        m_busy   = 1'b0;
  logic        m_rd     = 1'b0;
  logic        m_tmo    = 1'b0;
  logic [31:0] m_err    = '0;
  logic [1:0]  m_tx_no  = 2'd1;
  logic [5:0]  m_rx_no  = 6'd1;
  logic [7:0]  m_addr   = '0;
  logic [7:0]  m_wdata [2] = '{8'h00, 8'h00};
  logic [5:0]  m_len    = 6'd1;

  bus_row_t         bus_events [$];
  smbmts_pkg::res_t cmd_due [$];
  int               mismatches = 0;
  int               checked = 0;
  int               per_kind [8] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("[smbus_master_transfer_sequencer] ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic smbmts_pkg::res_t bus_result(int txv, int txb, int st, int sp, int ak,
                                                  int rv, int idx, int dat, int br, int bz,
                                                  int to, int err);
    smbmts_pkg::res_t r;
    r.tx_valid       = 1'(txv);
    r.tx_byte        = 8'(txb);
    r.start_cmd      = 1'(st);
    r.stop_cmd       = 1'(sp);
    r.ack_out        = 1'(ak);
    r.rx_store_valid = 1'(rv);
    r.rx_index       = 5'(idx);
    r.rx_data        = 8'(dat);
    r.bus_reset      = 1'(br);
    r.busy_res       = 1'(bz);
    r.timed_out      = 1'(to);
    r.error_count    = 32'(err);
    return r;
  endfunction

  function automatic bus_txn_t ev(logic [2:0] kind, int addr, int wb0, int wb1, int rlen,
                                  int ack, int arb, int rxb);
    bus_txn_t t;
    t.kind = kind;
    t.addr = 8'(addr);
    t.wb0  = 8'(wb0);
    t.wb1  = 8'(wb1);
    t.rlen = 8'(rlen);
    t.ack  = 1'(ack);
    t.arb  = 1'(arb);
    t.rxb  = 8'(rxb);
    return t;
  endfunction

  function automatic bus_txn_t rand_txn(logic [2:0] kind, bit clean);
    bus_txn_t t;
    t.kind = kind;
    t.addr = 8'($urandom_range(0, 255));
    t.wb0  = 8'($urandom_range(0, 255));
    t.wb1  = 8'($urandom_range(0, 255));
    t.rlen = 8'($urandom_range(0, 255));
    t.rxb  = 8'($urandom_range(0, 255));
    t.ack  = clean ? 1'b1 : 1'($urandom_range(0, 1));
    t.arb  = clean ? 1'b0 : ($urandom_range(0, 3) == 0);
    return t;
  endfunction

  // occasionally swap a well-formed transaction for a random one
  function automatic bus_txn_t jitter(bus_txn_t t);
    if ($urandom_range(0, 24) == 0) begin
      return rand_txn(3'($urandom_range(0, 6)), 1'b0);
    end
    return t;
  endfunction

  function automatic void add_row(bus_txn_t t, bit typed, smbmts_pkg::res_t want);
    bus_row_t row;
    row.txn   = t;
    row.typed = typed;
    row.want  = want;
    bus_events.push_back(row);
  endfunction

  function automatic smbmts_pkg::res_t sequence_step(bus_txn_t t);
    smbmts_pkg::res_t r;
    logic [1:0]       idx;
    r = '0;
    if (t.kind == smbmts_pkg::REQ_WRITE || t.kind == smbmts_pkg::REQ_READ) begin
      if (!m_busy) begin
        m_busy = 1'b1;
        m_tmo = 1'b0;
        m_addr = t.addr;
        r.start_cmd = 1'b1;
        if (t.kind == smbmts_pkg::REQ_WRITE) begin
          m_rd = 1'b0;
          m_wdata[0] = t.wb0;
          m_wdata[1] = t.wb1;
        end else begin
          m_rd = 1'b1;
          if (t.rlen == 8'd0) m_len = 6'd1;
          else if (t.rlen > smbmts_pkg::READ_DEPTH_DEF) m_len = 6'(smbmts_pkg::READ_DEPTH_DEF);
          else m_len = t.rlen[5:0];
        end
      end
    end else if (t.kind == smbmts_pkg::REQ_TIMEOUT) begin
      r.bus_reset = 1'b1;
      m_busy = 1'b0;
      m_tmo = 1'b1;
    end else if (t.kind != REQ_UNDEF) begin
      if (t.arb || t.kind == smbmts_pkg::REQ_OTHER) begin
        r.bus_reset = 1'b1;
        m_busy = 1'b0;
        m_err = m_err + 32'd1;
      end else if (t.kind == smbmts_pkg::REQ_START_SENT) begin
        r.tx_valid = 1'b1;
        r.tx_byte = (m_addr & smbmts_pkg::ADDR_MASK) | {7'd0, m_rd};
        m_rx_no = 6'd1;
        m_tx_no = 2'd1;
      end else if (t.kind == smbmts_pkg::REQ_BYTE_SENT) begin
        if (!t.ack) begin
          r.stop_cmd = 1'b1;
          r.start_cmd = 1'b1;
          m_err = m_err + 32'd1;
        end else if (!m_rd) begin
          if (m_tx_no >= 2'd1 && m_tx_no <= 2'(smbmts_pkg::WRITE_BYTES_DEF)) begin
            idx = m_tx_no - 2'd1;
            r.tx_valid = 1'b1;
            r.tx_byte = m_wdata[idx[0]];
            m_tx_no = m_tx_no + 2'd1;
          end else begin
            r.stop_cmd = 1'b1;
            m_busy = 1'b0;
          end
        end
      end else begin
        r.rx_store_valid = 1'b1;
        r.rx_index = 5'(m_rx_no - 6'd1);
        r.rx_data = t.rxb;
        if (m_rx_no < m_len) begin
          r.ack_out = 1'b1;
          m_rx_no = m_rx_no + 6'd1;
        end else begin
          r.stop_cmd = 1'b1;
          m_busy = 1'b0;
        end
      end
    end
    r.busy_res = m_busy;
    r.timed_out = m_tmo;
    r.error_count = m_err;
    return r;
  endfunction

  function automatic string field_diff(smbmts_pkg::res_t got, smbmts_pkg::res_t want);
    string s;
    s = "";
    if (got.tx_valid !== want.tx_valid) s = {s, " tx_valid"};
    if (got.tx_byte !== want.tx_byte) s = {s, " tx_byte"};
    if (got.start_cmd !== want.start_cmd) s = {s, " start_cmd"};
    if (got.stop_cmd !== want.stop_cmd) s = {s, " stop_cmd"};
    if (got.ack_out !== want.ack_out) s = {s, " ack_out"};
    if (got.rx_store_valid !== want.rx_store_valid) s = {s, " rx_store_valid"};
    if (got.rx_index !== want.rx_index) s = {s, " rx_index"};
    if (got.rx_data !== want.rx_data) s = {s, " rx_data"};
    if (got.bus_reset !== want.bus_reset) s = {s, " bus_reset"};
    if (got.busy_res !== want.busy_res) s = {s, " busy_res"};
    if (got.timed_out !== want.timed_out) s = {s, " timed_out"};
    if (got.error_count !== want.error_count) s = {s, " error_count"};
    return s;
  endfunction

  always @(posedge clk) begin
    smbmts_pkg::res_t want;
    string            diff;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_due.size() == 0) begin
        note_mismatch($sformatf("result %h with no transaction pending", seen));
      end else begin
        want = cmd_due.pop_front();
        diff = field_diff(seen, want);
        if (diff != "") begin
          note_mismatch($sformatf("result %0d wrong in%s: got %h want %h",
                                  checked, diff, seen, want));
        end
      end
      checked++;
    end
  end

  // result side stalls
  initial begin
    int n;
    bit smooth_rx;
    smooth_rx = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      n = smooth_rx ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) smooth_rx = !smooth_rx;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  initial begin
    bus_txn_t         t;
    bus_row_t         row;
    smbmts_pkg::res_t want;
    int               pick;
    int               n;
    int               nb;
    int               gap;
    int               waited;
    bit               smooth_tx;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = smbmts_pkg::REQ_WRITE;
    in_target_address = '0;
    in_write_byte_first = '0;
    in_write_byte_second = '0;
    in_read_length = '0;
    in_ack_in = 1'b0;
    in_arb_lost = 1'b0;
    in_rx_byte = '0;
    smooth_tx = 1'b0;

    // directed transactions
    add_row(ev(smbmts_pkg::REQ_OTHER, 8'h00, 0, 0, 0, 1, 0, 0), 1,
            bus_result(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 1));
    add_row(ev(smbmts_pkg::REQ_TIMEOUT, 8'hFF, 0, 0, 0, 0, 1, 0), 1,
            bus_result(0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1));
    add_row(ev(smbmts_pkg::REQ_WRITE, 8'hFF, 8'h00, 8'hFF, 8'h00, 1, 1, 8'h00), 1,
            bus_result(0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    add_row(ev(smbmts_pkg::REQ_WRITE, 8'h00, 8'hAA, 8'h55, 8'hFF, 0, 0, 8'hFF), 1,
            bus_result(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    add_row(ev(smbmts_pkg::REQ_START_SENT, 8'h00, 0, 0, 0, 0, 0, 0), 1,
            bus_result(1, 8'hFE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_READ, 8'h00, 0, 0, 8'h00, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_START_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_RCVD, 0, 0, 0, 0, 1, 0, 8'hFF), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_RCVD, 0, 0, 0, 0, 1, 0, 8'h00), 0, '0);
    add_row(ev(smbmts_pkg::REQ_READ, 8'h5A, 0, 0, 8'hFF, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_START_SENT, 0, 0, 0, 0, 1, 1, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_READ, 8'hA5, 0, 0, 8'd33, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_START_SENT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_SENT, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_RCVD, 0, 0, 0, 0, 1, 0, 8'h3C), 0, '0);
    add_row(ev(smbmts_pkg::REQ_TIMEOUT, 0, 0, 0, 0, 1, 0, 0), 0, '0);
    add_row(ev(REQ_UNDEF, 8'h77, 8'h11, 8'h22, 8'h05, 1, 1, 8'h99), 0, '0);
    add_row(ev(smbmts_pkg::REQ_WRITE, 8'h81, 8'h12, 8'h34, 0, 1, 0, 0), 0, '0);
    add_row(ev(smbmts_pkg::REQ_BYTE_RCVD, 0, 0, 0, 0, 1, 0, 8'hC3), 0, '0);
    add_row(ev(smbmts_pkg::REQ_OTHER, 0, 0, 0, 0, 1, 0, 0), 0, '0);

    // random traffic, mostly whole transfers
    n = bus_events.size() + RANDOM_ITEMS;
    while (bus_events.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        add_row(jitter(rand_txn(smbmts_pkg::REQ_WRITE, 1'b1)), 0, '0);
        add_row(jitter(rand_txn(smbmts_pkg::REQ_START_SENT, 1'b1)), 0, '0);
        nb = ($urandom_range(0, 9) == 0) ? 3 + $urandom_range(1, 2) : 3;
        repeat (nb) add_row(jitter(rand_txn(smbmts_pkg::REQ_BYTE_SENT, 1'b1)), 0, '0);
      end else if (pick < 80) begin
        t = rand_txn(smbmts_pkg::REQ_READ, 1'b1);
        if ($urandom_range(0, 7) != 0) t.rlen = 8'($urandom_range(1, 6));
        add_row(jitter(t), 0, '0);
        add_row(jitter(rand_txn(smbmts_pkg::REQ_START_SENT, 1'b1)), 0, '0);
        add_row(jitter(rand_txn(smbmts_pkg::REQ_BYTE_SENT, 1'b1)), 0, '0);
        nb = (t.rlen == 8'd0) ? 1 :
             (t.rlen > smbmts_pkg::READ_DEPTH_DEF ? smbmts_pkg::READ_DEPTH_DEF : int'(t.rlen));
        if ($urandom_range(0, 9) == 0) nb += $urandom_range(1, 2);
        repeat (nb) add_row(jitter(rand_txn(smbmts_pkg::REQ_BYTE_RCVD, 1'b1)), 0, '0);
      end else begin
        add_row(rand_txn(3'($urandom_range(0, 6)), 1'b0), 0, '0);
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < bus_events.size(); i++) begin
      row = bus_events[i];
      gap = smooth_tx ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 39) == 0) smooth_tx = !smooth_tx;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_req_type <= row.txn.kind;
      in_target_address <= row.txn.addr;
      in_write_byte_first <= row.txn.wb0;
      in_write_byte_second <= row.txn.wb1;
      in_read_length <= row.txn.rlen;
      in_ack_in <= row.txn.ack;
      in_arb_lost <= row.txn.arb;
      in_rx_byte <= row.txn.rxb;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      want = sequence_step(row.txn);
      cmd_due.push_back(row.typed ? row.want : want);
      per_kind[row.txn.kind]++;
      @(negedge clk);
    end
    in_valid <= 1'b0;

    waited = 0;
    while (cmd_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (cmd_due.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", cmd_due.size()));
    end

    $display("sent %0d write and %0d read requests, %0d start, %0d byte sent, %0d received,",
             per_kind[smbmts_pkg::REQ_WRITE], per_kind[smbmts_pkg::REQ_READ],
             per_kind[smbmts_pkg::REQ_START_SENT], per_kind[smbmts_pkg::REQ_BYTE_SENT],
             per_kind[smbmts_pkg::REQ_BYTE_RCVD]);
    $display("%0d other status, %0d timeout, %0d undefined events; %0d results checked",
             per_kind[smbmts_pkg::REQ_OTHER], per_kind[smbmts_pkg::REQ_TIMEOUT],
             per_kind[REQ_UNDEF], checked);
    if (mismatches == 0) begin
      $display("[smbus_master_transfer_sequencer] OK");
    end else begin
      $display("[smbus_master_transfer_sequencer] ERROR");
    end
    $finish;
  end

endmodule
